### hdl/bts_pkg.sv
`default_nettype none

package bts_pkg;

  localparam int unsigned STORE_TEXELS_DEF    = 65536;
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;

  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned MAX_SIZE    = 256;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned RGB_W       = 3 * CH_W;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NEIGHBOURS  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = CFG_IDX_W'(1);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_SIZE)) begin
      r = SIZE_W'(MAX_SIZE);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/bts_ram.sv
`default_nettype none

module bts_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/bts_front.sv
`default_nettype none

module bts_front #(
  parameter int unsigned STORE_TEXELS    = bts_pkg::STORE_TEXELS_DEF,
  parameter int unsigned COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF,
  localparam int unsigned AW = (STORE_TEXELS > 1) ? $clog2(STORE_TEXELS) : 1,
  localparam int unsigned WW = 2 * COORD_FRAC_BITS + 1
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [bts_pkg::SIZE_W-1:0]             cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   mode_i,
  input  wire logic [bts_pkg::IDX_W-1:0]              texel_index_i,
  input  wire logic [bts_pkg::CH_W-1:0]               texel_red_i,
  input  wire logic [bts_pkg::CH_W-1:0]               texel_green_i,
  input  wire logic [bts_pkg::CH_W-1:0]               texel_blue_i,
  input  wire logic [bts_pkg::COORD_W-1:0]            coord_u_i,
  input  wire logic [bts_pkg::COORD_W-1:0]            coord_v_i,
  input  wire bts_pkg::q_status_t                     q_stat_i,
  output logic                                        push_o,
  output logic                                        e_sample_o,
  output logic                                        e_wen_o,
  output logic [bts_pkg::RGB_W-1:0]                   e_rgb_o,
  output logic [bts_pkg::NEIGHBOURS-1:0][AW-1:0]      e_addr_o,
  output logic [bts_pkg::NEIGHBOURS-1:0]              e_oob_o,
  output logic [bts_pkg::NEIGHBOURS-1:0][WW-1:0]      e_weight_o
);

  localparam int unsigned F  = COORD_FRAC_BITS;
  localparam int unsigned SW = F + bts_pkg::SIZE_W;
  localparam int unsigned RW = 2 * bts_pkg::CH_W + 1;
  localparam int unsigned XW = bts_pkg::CH_W;
  localparam int unsigned GW = F + 1;

  logic [bts_pkg::SIZE_W-1:0] width_q, height_q;

  logic                        adv;
  logic [F-1:0]                u_f, v_f;
  logic [SW-1:0]               su_d, sv_d;

  logic                        s1_valid_q, s1_sample_q;
  logic [bts_pkg::IDX_W-1:0]   s1_index_q;
  logic [bts_pkg::RGB_W-1:0]   s1_rgb_q;
  logic [SW-1:0]               s1_su_q, s1_sv_q;

  logic [XW-1:0]               x0, y0, x1, y1;
  logic [bts_pkg::SIZE_W-1:0]  x0p, y0p;
  logic [F-1:0]                fu, fv;
  logic [GW-1:0]               gu, gv;

  logic                        s2_valid_q, s2_sample_q;
  logic [bts_pkg::IDX_W-1:0]   s2_index_q;
  logic [bts_pkg::RGB_W-1:0]   s2_rgb_q;
  logic [XW-1:0]               s2_x0_q, s2_x1_q;
  logic [RW-1:0]               s2_row0_q, s2_row1_q;
  logic [bts_pkg::NEIGHBOURS-1:0][WW-1:0] s2_w_q;

  logic [bts_pkg::NEIGHBOURS-1:0][RW-1:0] addr;
  logic                        index_ok;

  assign cfg_ready_o = 1'b1;
  assign adv         = !s2_valid_q || !q_stat_i.full;
  assign in_ready_o  = adv;
  assign push_o      = s2_valid_q && !q_stat_i.full;

  assign u_f  = F'(coord_u_i);
  assign v_f  = F'(coord_v_i);
  assign su_d = SW'(u_f) * SW'(width_q);
  assign sv_d = SW'(v_f) * SW'(height_q);

  assign x0  = s1_su_q[F +: XW];
  assign y0  = s1_sv_q[F +: XW];
  assign fu  = s1_su_q[F-1:0];
  assign fv  = s1_sv_q[F-1:0];
  assign x0p = bts_pkg::SIZE_W'(x0) + bts_pkg::SIZE_W'(1);
  assign y0p = bts_pkg::SIZE_W'(y0) + bts_pkg::SIZE_W'(1);
  assign x1  = (x0p == width_q) ? '0 : x0p[XW-1:0];
  assign y1  = (y0p == height_q) ? '0 : y0p[XW-1:0];
  assign gu  = {1'b1, {F{1'b0}}} - GW'(fu);
  assign gv  = {1'b1, {F{1'b0}}} - GW'(fv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= bts_pkg::SIZE_W'(bts_pkg::MAX_SIZE);
      height_q   <= bts_pkg::SIZE_W'(bts_pkg::MAX_SIZE);
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bts_pkg::REG_TEX_WIDTH:  width_q  <= bts_pkg::clamp_size(cfg_data_i);
          bts_pkg::REG_TEX_HEIGHT: height_q <= bts_pkg::clamp_size(cfg_data_i);
          default: ;
        endcase
      end
      if (adv) begin
        s1_valid_q <= in_valid_i;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sample_q <= (mode_i == bts_pkg::MODE_SAMPLE);
      s1_index_q  <= texel_index_i;
      s1_rgb_q    <= {texel_red_i, texel_green_i, texel_blue_i};
      s1_su_q     <= su_d;
      s1_sv_q     <= sv_d;

      s2_sample_q <= s1_sample_q;
      s2_index_q  <= s1_index_q;
      s2_rgb_q    <= s1_rgb_q;
      s2_x0_q     <= x0;
      s2_x1_q     <= x1;
      s2_row0_q   <= RW'(y0) * RW'(width_q);
      s2_row1_q   <= RW'(y1) * RW'(width_q);
      s2_w_q[0]   <= WW'(gu) * WW'(gv);
      s2_w_q[1]   <= WW'(fu) * WW'(gv);
      s2_w_q[2]   <= WW'(gu) * WW'(fv);
      s2_w_q[3]   <= WW'(fu) * WW'(fv);
    end
  end

  assign addr[0]  = RW'(s2_x0_q) + s2_row0_q;
  assign addr[1]  = RW'(s2_x1_q) + s2_row0_q;
  assign addr[2]  = RW'(s2_x0_q) + s2_row1_q;
  assign addr[3]  = RW'(s2_x1_q) + s2_row1_q;
  assign index_ok = 32'(s2_index_q) < 32'(STORE_TEXELS);

  always_comb begin
    e_sample_o = s2_sample_q;
    e_wen_o    = !s2_sample_q && index_ok;
    e_rgb_o    = s2_rgb_q;
    e_weight_o = s2_w_q;
    for (int n = 0; n < bts_pkg::NEIGHBOURS; n++) begin
      e_addr_o[n] = AW'(addr[n]);
      e_oob_o[n]  = 32'(addr[n]) >= 32'(STORE_TEXELS);
    end
    if (!s2_sample_q) begin
      e_addr_o[0] = AW'(s2_index_q);
    end
  end

endmodule

`default_nettype wire

### hdl/bts_queue.sv
`default_nettype none

module bts_queue #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = bts_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [DATA_W-1:0]  data_i,
  input  wire logic               pop_i,
  output logic      [DATA_W-1:0]  data_o,
  output bts_pkg::q_status_t      stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PW:0]       count_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  assign stat_o.full  = (count_q == (PW + 1)'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/bts_back.sv
`default_nettype none

module bts_back #(
  parameter int unsigned STORE_TEXELS    = bts_pkg::STORE_TEXELS_DEF,
  parameter int unsigned COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF,
  localparam int unsigned AW = (STORE_TEXELS > 1) ? $clog2(STORE_TEXELS) : 1,
  localparam int unsigned WW = 2 * COORD_FRAC_BITS + 1
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire bts_pkg::q_status_t                     q_stat_i,
  output logic                                        pop_o,
  input  wire logic                                   e_sample_i,
  input  wire logic                                   e_wen_i,
  input  wire logic [bts_pkg::RGB_W-1:0]              e_rgb_i,
  input  wire logic [bts_pkg::NEIGHBOURS-1:0][AW-1:0] e_addr_i,
  input  wire logic [bts_pkg::NEIGHBOURS-1:0]         e_oob_i,
  input  wire logic [bts_pkg::NEIGHBOURS-1:0][WW-1:0] e_weight_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [bts_pkg::OUT_W-1:0]                   out_red_o,
  output logic [bts_pkg::OUT_W-1:0]                   out_green_o,
  output logic [bts_pkg::OUT_W-1:0]                   out_blue_o
);

  localparam int unsigned F   = COORD_FRAC_BITS;
  localparam int unsigned PRW = WW + bts_pkg::CH_W;
  localparam int unsigned SH  = 2 * F - bts_pkg::CH_W;
  localparam int unsigned NCH = 3;
  localparam int unsigned NB  = bts_pkg::NEIGHBOURS;

  logic adv;
  logic ram_we;

  logic [NB-1:0][bts_pkg::RGB_W-1:0] rdata;

  logic                      b1_valid_q;
  logic [NB-1:0]             b1_oob_q;
  logic [NB-1:0][WW-1:0]     b1_w_q;

  logic [NCH-1:0][NB-1:0][PRW-1:0] prod_d;
  logic                            b2_valid_q;
  logic [NCH-1:0][NB-1:0][PRW-1:0] b2_prod_q;

  logic                            b3_valid_q;
  logic [NCH-1:0][1:0][PRW-1:0]    b3_sum_q;

  logic [NCH-1:0][PRW-1:0]             acc;
  logic                                out_valid_q;
  logic [NCH-1:0][bts_pkg::OUT_W-1:0]  out_q;

  assign adv    = !out_valid_q || out_ready_i;
  assign pop_o  = adv && !q_stat_i.empty;
  assign ram_we = pop_o && !e_sample_i && e_wen_i;

  for (genvar gi = 0; gi < NB; gi++) begin : g_bank
    bts_ram #(
      .WIDTH (bts_pkg::RGB_W),
      .DEPTH (STORE_TEXELS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (e_addr_i[0]),
      .wdata_i (e_rgb_i),
      .re_i    (adv),
      .raddr_i (e_addr_i[gi]),
      .rdata_o (rdata[gi])
    );
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      for (int n = 0; n < NB; n++) begin
        logic [bts_pkg::CH_W-1:0] byte_v;
        byte_v = b1_oob_q[n] ? '0
                 : rdata[n][(NCH - 1 - c) * bts_pkg::CH_W +: bts_pkg::CH_W];
        prod_d[c][n] = PRW'(byte_v) * PRW'(b1_w_q[n]);
      end
      acc[c] = b3_sum_q[c][0] + b3_sum_q[c][1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q  <= pop_o && e_sample_i;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      out_valid_q <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_oob_q  <= e_oob_i;
      b1_w_q    <= e_weight_i;
      b2_prod_q <= prod_d;
      for (int c = 0; c < NCH; c++) begin
        b3_sum_q[c][0] <= b2_prod_q[c][0] + b2_prod_q[c][1];
        b3_sum_q[c][1] <= b2_prod_q[c][2] + b2_prod_q[c][3];
        out_q[c]       <= acc[c][SH +: bts_pkg::OUT_W];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

endmodule

`default_nettype wire

### hdl/bilinear_texture_sampler_wrap_unit.sv
// Bilinear texture sampler with wrap addressing and an on-chip texel store.
// Items arrive on a valid/ready input channel. A load item writes one RGB
// texel at texel_index and gives no result; a sample item gives one result
// on the valid/ready output channel, each channel the bilinear blend of four
// neighbouring texels in Q8.8. Texture width and height are written through
// the configuration channel (index 0 width, index 1 height); the user must
// write them only while no item is in flight; the block does not enforce
// this. The channel is always ready and takes one write per cycle. One item
// is accepted per cycle unless a full queue holds the front end. A sample item
// passes two front stages that scale the coordinates and form addresses and
// weights, a four-entry queue and a back end that reads four store copies in
// parallel, one per neighbour, multiplies and sums in three stages. Every load
// writes all four copies at once. When the receiver stalls, the back end holds
// in place and the queue fills; the input keeps accepting until the queue is
// full. Reset empties the pipeline and queue and sets width and height to 256;
// the store is not cleared, and texels must be loaded before they are sampled.
`default_nettype none

module bilinear_texture_sampler_wrap_unit #(
  parameter int unsigned STORE_TEXELS    = bts_pkg::STORE_TEXELS_DEF,
  parameter int unsigned COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bts_pkg::SIZE_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           mode_i,
  input  wire logic [bts_pkg::IDX_W-1:0]      texel_index_i,
  input  wire logic [bts_pkg::CH_W-1:0]       texel_red_i,
  input  wire logic [bts_pkg::CH_W-1:0]       texel_green_i,
  input  wire logic [bts_pkg::CH_W-1:0]       texel_blue_i,
  input  wire logic [bts_pkg::COORD_W-1:0]    coord_u_i,
  input  wire logic [bts_pkg::COORD_W-1:0]    coord_v_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [bts_pkg::OUT_W-1:0]           out_red_o,
  output logic [bts_pkg::OUT_W-1:0]           out_green_o,
  output logic [bts_pkg::OUT_W-1:0]           out_blue_o
);

  localparam int unsigned F      = COORD_FRAC_BITS;
  localparam int unsigned AW     = (STORE_TEXELS > 1) ? $clog2(STORE_TEXELS) : 1;
  localparam int unsigned WW     = 2 * F + 1;
  localparam int unsigned NB     = bts_pkg::NEIGHBOURS;
  localparam int unsigned DATA_W = 2 + bts_pkg::RGB_W + NB * AW + NB + NB * WW;

  bts_pkg::q_status_t q_stat;
  logic               q_push, q_pop;
  logic [DATA_W-1:0]  q_wdata, q_rdata;

  logic                         f_sample, f_wen;
  logic [bts_pkg::RGB_W-1:0]    f_rgb;
  logic [NB-1:0][AW-1:0]        f_addr;
  logic [NB-1:0]                f_oob;
  logic [NB-1:0][WW-1:0]        f_weight;

  logic                         b_sample, b_wen;
  logic [bts_pkg::RGB_W-1:0]    b_rgb;
  logic [NB-1:0][AW-1:0]        b_addr;
  logic [NB-1:0]                b_oob;
  logic [NB-1:0][WW-1:0]        b_weight;

  bts_front #(
    .STORE_TEXELS    (STORE_TEXELS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .texel_index_i (texel_index_i),
    .texel_red_i   (texel_red_i),
    .texel_green_i (texel_green_i),
    .texel_blue_i  (texel_blue_i),
    .coord_u_i     (coord_u_i),
    .coord_v_i     (coord_v_i),
    .q_stat_i      (q_stat),
    .push_o        (q_push),
    .e_sample_o    (f_sample),
    .e_wen_o       (f_wen),
    .e_rgb_o       (f_rgb),
    .e_addr_o      (f_addr),
    .e_oob_o       (f_oob),
    .e_weight_o    (f_weight)
  );

  assign q_wdata = {f_sample, f_wen, f_rgb, f_addr, f_oob, f_weight};

  bts_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (bts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  assign {b_sample, b_wen, b_rgb, b_addr, b_oob, b_weight} = q_rdata;

  bts_back #(
    .STORE_TEXELS    (STORE_TEXELS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .e_sample_i  (b_sample),
    .e_wen_i     (b_wen),
    .e_rgb_i     (b_rgb),
    .e_addr_i    (b_addr),
    .e_oob_i     (b_oob),
    .e_weight_i  (b_weight),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

  a_stall_holds_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !q_pop)
    else $error("Queue popped while the output item was stalled.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("Item pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("Item popped from an empty queue.");

  a_status_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("Queue reports full and empty together.");

endmodule

`default_nettype wire

### bench/tb_bilinear_texture_sampler_wrap_unit.sv
`default_nettype none

module tb_bilinear_texture_sampler_wrap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE       = bts_pkg::STORE_TEXELS_DEF;
  localparam int unsigned FRAC_BITS   = bts_pkg::COORD_FRAC_BITS_DEF;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned END_WAIT    = 20;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned PHASES      = 8;

  localparam logic [bts_pkg::CFG_IDX_W-1:0] REG_SPARE = bts_pkg::CFG_IDX_W'(2);
  localparam logic [bts_pkg::CFG_IDX_W-1:0] REG_TOP   = '1;

  typedef struct packed {
    logic [bts_pkg::OUT_W-1:0] red;
    logic [bts_pkg::OUT_W-1:0] green;
    logic [bts_pkg::OUT_W-1:0] blue;
  } q88_rgb_t;

  typedef struct packed {
    logic                        mode;
    logic [bts_pkg::IDX_W-1:0]   addr;
    logic [bts_pkg::RGB_W-1:0]   rgb;
    logic [bts_pkg::COORD_W-1:0] u;
    logic [bts_pkg::COORD_W-1:0] v;
  } tex_item_t;

  typedef enum {ROW_LOAD, ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [bts_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [bts_pkg::SIZE_W-1:0]    reg_val;
    logic [bts_pkg::IDX_W-1:0]     addr;
    logic [bts_pkg::RGB_W-1:0]     rgb;
    logic [bts_pkg::COORD_W-1:0]   u;
    logic [bts_pkg::COORD_W-1:0]   v;
    bit                            fixed;
    q88_rgb_t                      want;
  } dir_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [bts_pkg::SIZE_W-1:0]        cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic                              mode_i;
  logic [bts_pkg::IDX_W-1:0]         texel_index_i;
  logic [bts_pkg::CH_W-1:0]          texel_red_i;
  logic [bts_pkg::CH_W-1:0]          texel_green_i;
  logic [bts_pkg::CH_W-1:0]          texel_blue_i;
  logic [bts_pkg::COORD_W-1:0]       coord_u_i;
  logic [bts_pkg::COORD_W-1:0]       coord_v_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [bts_pkg::OUT_W-1:0]         out_red_o;
  logic [bts_pkg::OUT_W-1:0]         out_green_o;
  logic [bts_pkg::OUT_W-1:0]         out_blue_o;

  logic [bts_pkg::RGB_W-1:0]  texel_mem [STORE];
  bit                         texel_loaded [STORE];
  logic [bts_pkg::SIZE_W-1:0] width_reg  = bts_pkg::SIZE_W'(256);
  logic [bts_pkg::SIZE_W-1:0] height_reg = bts_pkg::SIZE_W'(256);
  q88_rgb_t                   pending_colours [$];

  int unsigned err_count      = 0;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;
  bit          hold_req       = 1'b0;

  dir_row_t dir_rows [28] = '{
    '{ROW_LOAD,   '0, '0, 16'h0000, 24'hFF0080, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'h0000, 16'h0000, 1'b1, {16'hFF00, 16'h0000, 16'h8000}},
    '{ROW_LOAD,   '0, '0, 16'hFFFF, 24'h00FF00, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_LOAD,   '0, '0, 16'hAAAA, 24'h123456, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_LOAD,   '0, '0, 16'h5555, 24'hEDCBA9, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'h8000, 16'h8000, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'h0001, 16'hFFFE, 1'b0, '0},
    '{ROW_CFG, bts_pkg::REG_TEX_WIDTH,  9'd1, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_CFG, bts_pkg::REG_TEX_HEIGHT, 9'd1, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'hFFFF, 16'h1234, 1'b1, {16'hFF00, 16'h0000, 16'h8000}},
    '{ROW_CFG, bts_pkg::REG_TEX_WIDTH,  9'd0, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_CFG, bts_pkg::REG_TEX_HEIGHT, 9'd0, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 1'b1, {16'hFF00, 16'h0000, 16'h8000}},
    '{ROW_CFG, REG_SPARE, 9'd5,   '0, '0, '0, '0, 1'b0, '0},
    '{ROW_CFG, REG_TOP,   9'h1FF, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'h1234, 16'h5678, 1'b1, {16'hFF00, 16'h0000, 16'h8000}},
    '{ROW_LOAD,   '0, '0, 16'h0000, 24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'h0000, 16'h0000, 1'b1, {16'hFF00, 16'hFF00, 16'hFF00}},
    '{ROW_LOAD,   '0, '0, 16'h0000, 24'h000000, 16'h0000, 16'h0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'hABCD, 16'h4321, 1'b1, {16'h0000, 16'h0000, 16'h0000}},
    '{ROW_CFG, bts_pkg::REG_TEX_WIDTH,  9'h1FF, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_CFG, bts_pkg::REG_TEX_HEIGHT, 9'd300, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'hFFFF, 16'h0000, 1'b0, '0},
    '{ROW_CFG, bts_pkg::REG_TEX_WIDTH,  9'd3, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_CFG, bts_pkg::REG_TEX_HEIGHT, 9'd5, '0, '0, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'h5555, 16'hAAAA, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 1'b0, '0}
  };

  bilinear_texture_sampler_wrap_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .texel_index_i (texel_index_i),
    .texel_red_i   (texel_red_i),
    .texel_green_i (texel_green_i),
    .texel_blue_i  (texel_blue_i),
    .coord_u_i     (coord_u_i),
    .coord_v_i     (coord_v_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_size(input logic [bts_pkg::SIZE_W-1:0] s);
    int unsigned r;
    r = s;
    if (r < 1) begin
      r = 1;
    end else if (r > bts_pkg::MAX_SIZE) begin
      r = bts_pkg::MAX_SIZE;
    end
    return r;
  endfunction

  function automatic void tap_addrs(input logic [bts_pkg::COORD_W-1:0] u,
                                    input logic [bts_pkg::COORD_W-1:0] v,
                                    output int unsigned a00, output int unsigned a10,
                                    output int unsigned a01, output int unsigned a11,
                                    output int unsigned fu, output int unsigned fv);
    int unsigned w, h, su, sv, x0, y0, x1, y1;
    w  = eff_size(width_reg);
    h  = eff_size(height_reg);
    su = int'(u) * w;
    sv = int'(v) * h;
    x0 = su >> FRAC_BITS;
    y0 = sv >> FRAC_BITS;
    fu = su & ((1 << FRAC_BITS) - 1);
    fv = sv & ((1 << FRAC_BITS) - 1);
    x1 = (x0 + 1 == w) ? 0 : x0 + 1;
    y1 = (y0 + 1 == h) ? 0 : y0 + 1;
    a00 = x0 + y0 * w;
    a10 = x1 + y0 * w;
    a01 = x0 + y1 * w;
    a11 = x1 + y1 * w;
  endfunction

  function automatic q88_rgb_t blend_texels(input logic [bts_pkg::COORD_W-1:0] u,
                                            input logic [bts_pkg::COORD_W-1:0] v);
    int unsigned a00, a10, a01, a11, fu, fv, sh;
    longint unsigned gu, gv, w00, w10, w01, w11, acc;
    logic [bts_pkg::RGB_W-1:0] t00, t10, t01, t11;
    logic [bts_pkg::OUT_W-1:0] chan [3];
    tap_addrs(u, v, a00, a10, a01, a11, fu, fv);
    t00 = texel_mem[a00];
    t10 = texel_mem[a10];
    t01 = texel_mem[a01];
    t11 = texel_mem[a11];
    gu  = (longint'(1) << FRAC_BITS) - fu;
    gv  = (longint'(1) << FRAC_BITS) - fv;
    w00 = gu * gv;
    w10 = longint'(fu) * gv;
    w01 = gu * longint'(fv);
    w11 = longint'(fu) * longint'(fv);
    for (int ch = 0; ch < 3; ch++) begin
      sh  = 16 - 8 * ch;
      acc = longint'((t00 >> sh) & 8'hFF) * w00 + longint'((t10 >> sh) & 8'hFF) * w10
          + longint'((t01 >> sh) & 8'hFF) * w01 + longint'((t11 >> sh) & 8'hFF) * w11;
      chan[ch] = bts_pkg::OUT_W'(acc >> (2 * FRAC_BITS - 8));
    end
    return {chan[0], chan[1], chan[2]};
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
    err_count++;
  endtask

  task automatic send_item(input tex_item_t it, input bit fixed, input q88_rgb_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= it.mode;
    texel_index_i <= it.addr;
    texel_red_i   <= it.rgb[23:16];
    texel_green_i <= it.rgb[15:8];
    texel_blue_i  <= it.rgb[7:0];
    coord_u_i     <= it.u;
    coord_v_i     <= it.v;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.mode == bts_pkg::MODE_LOAD) begin
      texel_mem[it.addr]    = it.rgb;
      texel_loaded[it.addr] = 1'b1;
    end else begin
      pending_colours.push_back(fixed ? want : blend_texels(it.u, it.v));
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic issue_load(input logic [bts_pkg::IDX_W-1:0] addr,
                            input logic [bts_pkg::RGB_W-1:0] rgb);
    tex_item_t it;
    it      = '0;
    it.mode = bts_pkg::MODE_LOAD;
    it.addr = addr;
    it.rgb  = rgb;
    it.u    = bts_pkg::COORD_W'($urandom);
    it.v    = bts_pkg::COORD_W'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // Texels under the footprint that were never loaded get a random colour first.
  task automatic issue_sample(input logic [bts_pkg::COORD_W-1:0] u,
                              input logic [bts_pkg::COORD_W-1:0] v,
                              input bit fixed, input q88_rgb_t want);
    int unsigned a [4];
    int unsigned fu, fv;
    tex_item_t it;
    tap_addrs(u, v, a[0], a[1], a[2], a[3], fu, fv);
    foreach (a[i]) begin
      if (!texel_loaded[a[i]]) begin
        issue_load(bts_pkg::IDX_W'(a[i]), bts_pkg::RGB_W'($urandom));
      end
    end
    it      = '0;
    it.mode = bts_pkg::MODE_SAMPLE;
    it.addr = bts_pkg::IDX_W'($urandom);
    it.rgb  = bts_pkg::RGB_W'($urandom);
    it.u    = u;
    it.v    = v;
    send_item(it, fixed, want);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_colours.size() != 0);
  endtask

  task automatic write_reg(input logic [bts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bts_pkg::SIZE_W-1:0] val);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bts_pkg::REG_TEX_WIDTH: begin
        width_reg = val;
      end
      bts_pkg::REG_TEX_HEIGHT: begin
        height_reg = val;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [bts_pkg::COORD_W-1:0] pick_coord();
    logic [bts_pkg::COORD_W-1:0] c;
    case ($urandom_range(7))
      0: c = '0;
      1: c = '1;
      2: c = bts_pkg::COORD_W'(16'h8000);
      default: c = bts_pkg::COORD_W'($urandom);
    endcase
    return c;
  endfunction

  task automatic run_phase(input int unsigned phase);
    int unsigned start, area, pick;
    bit          mid_done;
    case (phase)
      0: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'd1);
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'd1);
      end
      1: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'd256);
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'd256);
      end
      2: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'd0);
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'd300);
      end
      3: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'd2);
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'd256);
      end
      4: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'd256);
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'd1);
      end
      5: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'($urandom_range(1, 16)));
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'($urandom_range(1, 16)));
        write_reg(bts_pkg::CFG_IDX_W'($urandom_range(2, 255)), 9'($urandom));
      end
      6: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'($urandom_range(1, 64)));
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'($urandom_range(1, 64)));
      end
      default: begin
        write_reg(bts_pkg::REG_TEX_WIDTH, 9'd3);
        write_reg(bts_pkg::REG_TEX_HEIGHT, 9'd5);
      end
    endcase
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
    area     = eff_size(width_reg) * eff_size(height_reg);
    start    = items_sent;
    mid_done = 1'b0;
    while (items_sent - start < PHASE_ITEMS) begin
      if (!mid_done && items_sent - start >= PHASE_ITEMS / 2) begin
        mid_done = 1'b1;
        if (phase == 0) begin
          hold_req = 1'b1;
        end else if (phase == 1) begin
          wait_drained();
        end
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        issue_sample(pick_coord(), pick_coord(), 1'b0, '0);
      end else if (pick < 90) begin
        issue_load(bts_pkg::IDX_W'($urandom_range(area - 1)), bts_pkg::RGB_W'($urandom));
      end else begin
        issue_load(bts_pkg::IDX_W'($urandom), bts_pkg::RGB_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    mode_i        = bts_pkg::MODE_LOAD;
    texel_index_i = '0;
    texel_red_i   = '0;
    texel_green_i = '0;
    texel_blue_i  = '0;
    coord_u_i     = '0;
    coord_v_i     = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_LOAD:   issue_load(dir_rows[i].addr, dir_rows[i].rgb);
        ROW_SAMPLE: issue_sample(dir_rows[i].u, dir_rows[i].v, dir_rows[i].fixed,
                                 dir_rows[i].want);
        default:    write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      endcase
    end
    for (int unsigned p = 0; p < PHASES; p++) begin
      run_phase(p);
    end
    wait_drained();
    repeat (END_WAIT) @(negedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    q88_rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colours.size() == 0) begin
        report_mismatch("result with no sample waiting", out_red_o, '0);
      end else begin
        want = pending_colours.pop_front();
        if (out_red_o !== want.red) report_mismatch("out_red", out_red_o, want.red);
        if (out_green_o !== want.green) report_mismatch("out_green", out_green_o, want.green);
        if (out_blue_o !== want.blue) report_mismatch("out_blue", out_blue_o, want.blue);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

endmodule

`default_nettype wire

### bilinear_texture_sampler_wrap_unit.f
hdl/bts_pkg.sv
hdl/bts_ram.sv
hdl/bts_front.sv
hdl/bts_queue.sv
hdl/bts_back.sv
hdl/bilinear_texture_sampler_wrap_unit.sv
bench/tb_bilinear_texture_sampler_wrap_unit.sv
